@@ design/rhmf_pkg.sv @@
// ----------------------------------------------------------------------------
// rhmf_pkg: shared definitions for the running median filter
// Sizes, configuration register indexes and reset values, request codes, payload
// structs, the cell link struct, the sequencer state type and the median rank.
// ----------------------------------------------------------------------------
package rhmf_pkg;

  // Pixel and geometry limits.
  localparam int LEVELS     = 256;
  localparam int PIX_W      = $clog2(LEVELS);
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_RADIUS = 3;

  // Line store: one slot per row, enough row slots for the rows in flight.
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int SLOT_W      = $clog2(2 * MAX_RADIUS + 2);
  localparam int ADDR_W      = SLOT_W + COL_W;
  localparam int STORE_DEPTH = 1 << ADDR_W;

  // Window and sorting chain.
  localparam int SIDE_MAX  = 2 * MAX_RADIUS + 1;
  localparam int CHAIN_LEN = SIDE_MAX * SIDE_MAX;
  localparam int OFS_W     = $clog2(SIDE_MAX);

  // Register widths.
  localparam int W_W        = 11;
  localparam int H_W        = 12;
  localparam int R_W        = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int DELAY_W    = 12;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_RADIUS = 2'd2;

  // Register reset values.
  localparam logic [W_W-1:0] RST_IMAGE_WIDTH   = 11'd640;
  localparam logic [H_W-1:0] RST_IMAGE_HEIGHT  = 12'd480;
  localparam logic [R_W-1:0] RST_WINDOW_RADIUS = 2'd1;

  // Request codes.
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [PIX_W-1:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic             frame_last;
  } out_item_t;

  // What one sorting cell hands to its right-hand neighbor.
  typedef struct packed {
    logic             take;
    logic             valid;
    logic [PIX_W-1:0] value;
  } cell_link_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_PASS,
    S_GATHER,
    S_DRAIN,
    S_MED,
    S_OUT
  } rhmf_state_t;

  // Position of the median in an ascending sort of a window of radius r.
  function automatic int rank_of(input int r);
    return 2 * r * (r + 1);
  endfunction

endpackage

@@ design/rhmf_line_store.sv @@
// ----------------------------------------------------------------------------
// rhmf_line_store: pixel line buffer
// One write port and one registered read port; rows live in slots by the
// low bits of the row number.
// ----------------------------------------------------------------------------
module rhmf_line_store import rhmf_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [PIX_W-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [PIX_W-1:0]  rd_data
);

  logic [PIX_W-1:0] mem [STORE_DEPTH];
  logic [PIX_W-1:0] rd_data_r;

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/rhmf_sort_cell.sv @@
// ----------------------------------------------------------------------------
// rhmf_sort_cell: one cell of the insertion sorting chain
// Holds one value; on an insertion it either keeps its value, takes the new
// value, or takes the value of its left neighbor that is being pushed right.
// ----------------------------------------------------------------------------
module rhmf_sort_cell import rhmf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clear,
  input  logic             ins_en,
  input  logic [PIX_W-1:0] ins_value,
  input  cell_link_t       left,
  output cell_link_t       right
);

  logic             valid_r;
  logic [PIX_W-1:0] value_r;
  logic             ins;

  // The new value belongs here or further left when this cell is empty or larger.
  assign ins = !valid_r || (ins_value < value_r);

  assign right.take  = ins;
  assign right.valid = valid_r;
  assign right.value = value_r;

  // Occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (clear) begin
      valid_r <= 1'b0;
    end else if (ins_en) begin
      if (left.take) begin
        valid_r <= left.valid;
      end else if (ins) begin
        valid_r <= 1'b1;
      end
    end
  end

  // Stored value.
  always_ff @(posedge clk) begin
    if (ins_en) begin
      if (left.take) begin
        value_r <= left.value;
      end else if (ins) begin
        value_r <= ins_value;
      end
    end
  end

endmodule

@@ design/rhmf_sort_chain.sv @@
// ----------------------------------------------------------------------------
// rhmf_sort_chain: row of sorting cells
// Keeps the window values in ascending order, one insertion per cycle.
// ----------------------------------------------------------------------------
module rhmf_sort_chain import rhmf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clear,
  input  logic                 ins_en,
  input  logic [PIX_W-1:0]     ins_value,
  output logic [PIX_W-1:0]     values [CHAIN_LEN],
  output logic [CHAIN_LEN-1:0] valids
);

  cell_link_t link [CHAIN_LEN+1];

  // The head of the chain never pushes anything in from the left.
  assign link[0] = '0;

  // Cells, each linked to its left neighbor.
  for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_cell
    rhmf_sort_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .clear     (clear),
      .ins_en    (ins_en),
      .ins_value (ins_value),
      .left      (link[i]),
      .right     (link[i+1])
    );
    assign values[i] = link[i+1].value;
    assign valids[i] = link[i+1].valid;
  end

endmodule

@@ design/running_histogram_median_filter.sv @@
// ----------------------------------------------------------------------------
// running_histogram_median_filter: square-window median filter
// Raster-order 8-bit pixels in, median-filtered pixels out, borders passed.
// ----------------------------------------------------------------------------
// Results lag the input by radius rows plus radius pixels; after the last pixel
// of a frame, flush transactions drain the remaining results, one each. An
// input transaction with no result leaves the sequencer idle; one for a border
// pixel passes the start, pass and output states, one for an interior pixel
// the start, gather, drain, median and output states. In gather the window is
// fetched from the line store's single read port, one pixel per cycle, into a
// chain of sorting cells. A finished result waits in an output register while
// the next transaction is accepted. A configuration write restarts the frame.
// ----------------------------------------------------------------------------
module running_histogram_median_filter import rhmf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers and their clamped values.
  logic [W_W-1:0]     img_w_r;
  logic [H_W-1:0]     img_h_r;
  logic [R_W-1:0]     win_r_r;
  logic [W_W-1:0]     w_eff;
  logic [H_W-1:0]     h_eff;
  logic [R_W-1:0]     r_eff;
  logic [DELAY_W-1:0] delay;
  logic               cfg_hit;

  // Sequencer and positions.
  rhmf_state_t        state_r, state_nxt;
  logic [W_W-1:0]     in_col_r;
  logic [H_W-1:0]     in_row_r;
  logic               in_done_r;
  logic [DELAY_W-1:0] pending_r;
  logic [W_W-1:0]     out_col_r;
  logic [H_W-1:0]     out_row_r;
  logic [OFS_W-1:0]   k_r, c_r;
  logic               rd_pend_r;
  logic [PIX_W-1:0]   res_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic               accept, is_pix, wr_en, in_last, start_emit;
  logic               interior, out_last, gather_last, load_out;
  logic [OFS_W-1:0]   side_m1;
  logic [SLOT_W-1:0]  win_slot;
  logic [W_W-1:0]     win_col;
  logic               rd_en, chain_clear;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic [PIX_W-1:0]   rd_data;
  logic [PIX_W-1:0]   chain_values [CHAIN_LEN];
  logic [CHAIN_LEN-1:0] chain_valids;
  logic [PIX_W-1:0]   med_value;
  logic               med_valid;

  // Register write decode.
  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && cfg_ready &&
                     (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT ||
                      cfg_index == CFG_WINDOW_RADIUS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= RST_IMAGE_WIDTH;
      img_h_r <= RST_IMAGE_HEIGHT;
      win_r_r <= RST_WINDOW_RADIUS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:   img_w_r <= cfg_data[W_W-1:0];
        CFG_IMAGE_HEIGHT:  img_h_r <= cfg_data[H_W-1:0];
        CFG_WINDOW_RADIUS: win_r_r <= cfg_data[R_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped geometry and the input-to-output lag.
  always_comb begin
    if (img_w_r < W_W'(3)) begin
      w_eff = W_W'(3);
    end else if (img_w_r > W_W'(MAX_WIDTH)) begin
      w_eff = W_W'(MAX_WIDTH);
    end else begin
      w_eff = img_w_r;
    end
    h_eff = (img_h_r < H_W'(3)) ? H_W'(3) : img_h_r;
    r_eff = (win_r_r == '0) ? R_W'(1) : win_r_r;
    delay = DELAY_W'({1'b0, w_eff} * r_eff) + DELAY_W'(r_eff);
  end

  // Position decode.
  assign accept     = in_valid && !in_stall;
  assign is_pix     = (in_data.req_type == REQ_PIXEL);
  assign wr_en      = accept && is_pix && !in_done_r;
  assign in_last    = (in_row_r == h_eff - H_W'(1)) && (in_col_r == w_eff - W_W'(1));
  assign start_emit = accept && ((is_pix && !in_done_r && pending_r >= delay) ||
                                 (in_data.req_type == REQ_FLUSH && in_done_r));
  assign interior   = (out_row_r >= H_W'(r_eff)) &&
                      ({1'b0, out_row_r} + (H_W+1)'(r_eff) < {1'b0, h_eff}) &&
                      (out_col_r >= W_W'(r_eff)) &&
                      ({1'b0, out_col_r} + (W_W+1)'(r_eff) < {1'b0, w_eff});
  assign out_last   = (out_row_r == h_eff - H_W'(1)) && (out_col_r == w_eff - W_W'(1));

  // Window walk.
  assign side_m1     = OFS_W'({r_eff, 1'b0});
  assign gather_last = (k_r == side_m1) && (c_r == side_m1);
  assign win_slot    = out_row_r[SLOT_W-1:0] - SLOT_W'(r_eff) + SLOT_W'(k_r);
  assign win_col     = out_col_r - W_W'(r_eff) + W_W'(c_r);
  assign wr_addr     = {in_row_r[SLOT_W-1:0], in_col_r[COL_W-1:0]};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (start_emit) state_nxt = S_START;
      S_START:  state_nxt = interior ? S_GATHER : S_PASS;
      S_PASS:   state_nxt = S_OUT;
      S_GATHER: if (gather_last) state_nxt = S_DRAIN;
      S_DRAIN:  state_nxt = S_MED;
      S_MED:    state_nxt = S_OUT;
      S_OUT:    if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_stall    = (state_r != S_IDLE);
    rd_en       = 1'b0;
    rd_addr     = {out_row_r[SLOT_W-1:0], out_col_r[COL_W-1:0]};
    chain_clear = 1'b0;
    load_out    = 1'b0;
    unique case (state_r)
      S_START: begin
        chain_clear = 1'b1;
        rd_en       = !interior;
      end
      S_GATHER: begin
        rd_en   = 1'b1;
        rd_addr = {win_slot, win_col[COL_W-1:0]};
      end
      S_OUT:   load_out = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else if (cfg_hit) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Input and output positions; a frame restarts after its last result.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      in_done_r <= 1'b0;
      pending_r <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      if (wr_en) begin
        pending_r <= pending_r + DELAY_W'(1);
        if (in_last) begin
          in_done_r <= 1'b1;
          in_col_r  <= '0;
          in_row_r  <= '0;
        end else if (in_col_r == w_eff - W_W'(1)) begin
          in_col_r <= '0;
          in_row_r <= in_row_r + H_W'(1);
        end else begin
          in_col_r <= in_col_r + W_W'(1);
        end
      end
      if (load_out) begin
        if (out_last) begin
          in_col_r  <= '0;
          in_row_r  <= '0;
          in_done_r <= 1'b0;
          pending_r <= '0;
          out_col_r <= '0;
          out_row_r <= '0;
        end else begin
          pending_r <= pending_r - DELAY_W'(1);
          if (out_col_r == w_eff - W_W'(1)) begin
            out_col_r <= '0;
            out_row_r <= out_row_r + H_W'(1);
          end else begin
            out_col_r <= out_col_r + W_W'(1);
          end
        end
      end
    end
  end

  // Window offsets and the read-data-ready flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r       <= '0;
      c_r       <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= (state_r == S_GATHER);
      if (state_r == S_START) begin
        k_r <= '0;
        c_r <= '0;
      end else if (state_r == S_GATHER) begin
        if (c_r == side_m1) begin
          c_r <= '0;
          k_r <= k_r + OFS_W'(1);
        end else begin
          c_r <= c_r + OFS_W'(1);
        end
      end
    end
  end

  // Line store.
  rhmf_line_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data.pixel),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sorting chain for the window.
  rhmf_sort_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (chain_clear),
    .ins_en    (rd_pend_r),
    .ins_value (rd_data),
    .values    (chain_values),
    .valids    (chain_valids)
  );

  // Median tap for the configured radius.
  always_comb begin
    unique case (r_eff)
      2'd2: begin
        med_value = chain_values[rank_of(2)];
        med_valid = chain_valids[rank_of(2)];
      end
      2'd3: begin
        med_value = chain_values[rank_of(3)];
        med_valid = chain_valids[rank_of(3)];
      end
      default: begin
        med_value = chain_values[rank_of(1)];
        med_valid = chain_valids[rank_of(1)];
      end
    endcase
  end

  // Result value.
  always_ff @(posedge clk) begin
    if (state_r == S_PASS) begin
      res_r <= rd_data;
    end else if (state_r == S_MED) begin
      res_r <= med_value;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.out_pixel  <= res_r;
      out_data_r.frame_last <= out_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Between transactions the pending count never passes the lag.
  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (pending_r <= delay))
    else $error("pending count exceeds the output lag");

  // A new result only appears from the output state.
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result appeared outside the output state");

  // The whole window has been inserted when the median is taken.
  a_median_filled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MED) |-> med_valid)
    else $error("median taken from an empty cell");

endmodule

@@ sim/median_stream_checker.sv @@
// ----------------------------------------------------------------------------
// median_stream_checker: result predictor and comparator for the median filter
// Watches the pixel, result and register channels of the filter, predicts
// each filtered pixel from its own copy of the frame state and compares every
// accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module median_stream_checker import rhmf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending,
  output int                    checked
);

  // Ring of recent pixels, sized for the largest window and row.
  localparam int RING = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;

  logic [W_W-1:0]   width_reg;
  logic [H_W-1:0]   height_reg;
  logic [R_W-1:0]   radius_reg;
  logic [PIX_W-1:0] pixel_ring [RING];
  int unsigned      in_pos;
  int unsigned      out_pos;
  out_item_t        expected_pixels[$];

  assign pending = expected_pixels.size();

  initial begin
    foreach (pixel_ring[i]) pixel_ring[i] = '0;
    errors  = 0;
    checked = 0;
  end

  function automatic int unsigned cols();
    if (width_reg < 3) return 3;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned rows();
    return (height_reg < 3) ? 3 : height_reg;
  endfunction

  function automatic int unsigned radius();
    if (radius_reg < 1) return 1;
    if (radius_reg > MAX_RADIUS) return MAX_RADIUS;
    return radius_reg;
  endfunction

  function automatic logic [PIX_W-1:0] stored_pixel(int unsigned row, int unsigned col);
    return pixel_ring[(row * cols() + col) % RING];
  endfunction

  // Produce the next output pixel in raster order and advance the frame.
  function automatic out_item_t next_filtered();
    int unsigned w, h, r, total, y, x, side, thresh, acc;
    int          hist [LEVELS];
    out_item_t   res;
    w     = cols();
    h     = rows();
    r     = radius();
    total = w * h;
    y     = out_pos / w;
    x     = out_pos % w;
    if (y >= r && y + r < h && x >= r && x + r < w) begin
      // Interior: smallest level with more than half the window at or below.
      side   = 2 * r + 1;
      thresh = side * side / 2 + 1;
      foreach (hist[m]) hist[m] = 0;
      for (int unsigned k = y - r; k <= y + r; k++)
        for (int unsigned c = x - r; c <= x + r; c++)
          hist[stored_pixel(k, c)]++;
      acc = 0;
      res.out_pixel = '0;
      for (int m = 0; m < LEVELS; m++) begin
        acc += hist[m];
        if (acc >= thresh) begin
          res.out_pixel = m[PIX_W-1:0];
          break;
        end
      end
    end else begin
      res.out_pixel = stored_pixel(y, x);
    end
    res.frame_last = (out_pos + 1 == total);
    out_pos++;
    if (out_pos >= total) begin
      in_pos  = 0;
      out_pos = 0;
    end
    return res;
  endfunction

  // Update the prediction for one accepted pixel or flush transaction.
  function automatic void accept_request(in_item_t req);
    int unsigned total, delay;
    total = cols() * rows();
    delay = radius() * cols() + radius();
    if (req.req_type == REQ_PIXEL) begin
      if (in_pos < total) begin
        pixel_ring[in_pos % RING] = req.pixel;
        in_pos++;
        if (out_pos + delay + 1 <= in_pos && out_pos < total)
          expected_pixels.push_back(next_filtered());
      end
    end else if (in_pos >= total && out_pos < total) begin
      expected_pixels.push_back(next_filtered());
    end
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      width_reg  = RST_IMAGE_WIDTH;
      height_reg = RST_IMAGE_HEIGHT;
      radius_reg = RST_WINDOW_RADIUS;
      in_pos     = 0;
      out_pos    = 0;
      expected_pixels.delete();
    end else begin
      // Results are compared against the oldest prediction.
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual pixel %0d last %0b",
                   $time, out_data.out_pixel, out_data.frame_last);
        end else begin
          want = expected_pixels.pop_front();
          checked++;
          if (out_data.out_pixel !== want.out_pixel) begin
            errors++;
            $display("%0t: out_pixel mismatch, expected %0d, actual %0d",
                     $time, want.out_pixel, out_data.out_pixel);
          end
          if (out_data.frame_last !== want.frame_last) begin
            errors++;
            $display("%0t: frame_last mismatch, expected %0b, actual %0b",
                     $time, want.frame_last, out_data.frame_last);
          end
        end
      end
      // A register write restarts the frame.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH: begin
            width_reg = cfg_data[W_W-1:0];
            in_pos = 0;
            out_pos = 0;
          end
          CFG_IMAGE_HEIGHT: begin
            height_reg = cfg_data[H_W-1:0];
            in_pos = 0;
            out_pos = 0;
          end
          CFG_WINDOW_RADIUS: begin
            radius_reg = cfg_data[R_W-1:0];
            in_pos = 0;
            out_pos = 0;
          end
          default: ;
        endcase
      end
      if (in_valid && !in_stall) accept_request(in_data);
    end
  end

endmodule

@@ sim/running_histogram_median_filter_test.sv @@
// ----------------------------------------------------------------------------
// running_histogram_median_filter_test: stimulus and verdict for the filter
// Drives frames of random geometry and content with random gaps and result
// stalls, including clamped register values and ignored flush and pixel
// transactions; a checker beside the filter predicts and compares results.
// ----------------------------------------------------------------------------
module running_histogram_median_filter_test;
  import rhmf_pkg::*;

  localparam int IDLE_LIMIT  = 4000;
  localparam int SETTLE      = 80;
  localparam int ITEM_TARGET = 1350;

  // Index with no register behind it; a write there changes nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REGISTER = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors;
  int                    pending;
  int                    checked;
  int                    idle_cycles;
  int                    items_sent;
  int                    frames_run;
  bit                    calm;

  running_histogram_median_filter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  median_stream_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked)
  );

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    idle_cycles = 0;
  end

  always #6 clk = ~clk;

  // Gap length: mostly short, a few long, none during calm stretches.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // Watchdog on cycles in which no transaction moves on any channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result-side stalls.
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_stall <= 1'b1;
      repeat (pick_gap()) @(negedge clk);
      out_stall <= 1'b0;
      repeat (pick_gap()) @(negedge clk);
    end
  end

  // Send one transaction; entered and left at a falling edge.
  task automatic send_request(logic kind, logic [PIX_W-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{req_type: kind, pixel: value};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  // Hold the sender until every predicted result is out and the filter settles.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(int raw_w, int raw_h, int raw_r);
    drain_results();
    write_register(CFG_IMAGE_WIDTH, CFG_DATA_W'(raw_w));
    write_register(CFG_IMAGE_HEIGHT, CFG_DATA_W'(raw_h));
    write_register(CFG_WINDOW_RADIUS, CFG_DATA_W'(raw_r));
  endtask

  // One full frame: pixels, optional ignored transactions, then the flushes.
  task automatic run_frame(int raw_w, int raw_h, int raw_r, int style, bit noisy);
    int w, h, r, total, delay, flushes;
    logic [PIX_W-1:0] value;
    w = raw_w[W_W-1:0];
    w = (w < 3) ? 3 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
    h = raw_h[H_W-1:0];
    h = (h < 3) ? 3 : h;
    r = raw_r[R_W-1:0];
    r = (r < 1) ? 1 : r;
    total = w * h;
    delay = r * w + r;
    flushes = (delay < total) ? delay : total;
    configure(raw_w, raw_h, raw_r);
    calm = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < total; i++) begin
      case (style)
        0: value = PIX_W'($urandom_range(0, 255));
        1: value = 8'd77;
        2: value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default: value = PIX_W'($urandom_range(120, 124));
      endcase
      // An early flush is ignored.
      if (noisy && $urandom_range(0, 19) == 0)
        send_request(REQ_FLUSH, PIX_W'($urandom_range(0, 255)));
      send_request(REQ_PIXEL, value);
    end
    // Pixels past the frame end are ignored while results are pending.
    if (noisy && $urandom_range(0, 2) == 0)
      send_request(REQ_PIXEL, PIX_W'($urandom_range(0, 255)));
    for (int i = 0; i < flushes; i++) send_request(REQ_FLUSH, PIX_W'($urandom_range(0, 255)));
    // A flush with nothing pending is ignored.
    if (noisy && $urandom_range(0, 3) == 0) send_request(REQ_FLUSH, 8'h00);
    frames_run++;
    calm = 1'b0;
  endtask

  initial begin
    int raw_w, raw_h, raw_r;
    items_sent = 0;
    frames_run = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset geometry: a few pixels, too few to reach the first result.
    send_request(REQ_PIXEL, 8'h00);
    send_request(REQ_PIXEL, 8'hFF);
    send_request(REQ_FLUSH, 8'hAA);
    send_request(REQ_PIXEL, 8'h55);

    // Smallest frame with one interior pixel, extremes of the pixel range.
    configure(3, 3, 1);
    send_request(REQ_FLUSH, 8'h00);
    send_request(REQ_PIXEL, 8'hFF);
    send_request(REQ_PIXEL, 8'h00);
    send_request(REQ_PIXEL, 8'hFF);
    send_request(REQ_PIXEL, 8'h00);
    send_request(REQ_PIXEL, 8'h80);
    send_request(REQ_PIXEL, 8'hFF);
    send_request(REQ_PIXEL, 8'h00);
    send_request(REQ_PIXEL, 8'hFF);
    send_request(REQ_PIXEL, 8'h01);
    repeat (4) send_request(REQ_FLUSH, 8'h00);

    // Largest register values, clamped; abandoned before any result.
    configure(2047, 4095, 3);
    repeat (6) send_request(REQ_PIXEL, PIX_W'($urandom_range(0, 255)));
    drain_results();
    write_register(CFG_NO_REGISTER, 12'hFFF);

    // Window larger than the image, and all-zero registers clamped up.
    run_frame(3, 3, 3, 0, 1'b0);
    run_frame(0, 0, 0, 2, 1'b0);

    // Random frames, with one wide frame partway through.
    while (items_sent < ITEM_TARGET) begin
      if (frames_run == 8) begin
        run_frame(130, 3, 1, 0, 1'b1);
      end else begin
        raw_w = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2)
              : ($urandom_range(0, 4) == 0) ? $urandom_range(17, 40) : $urandom_range(3, 16);
        raw_w = raw_w | ($urandom_range(0, 1) << 11);
        raw_h = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 9);
        raw_r = $urandom_range(0, 3) | ($urandom_range(0, 1023) << 2);
        run_frame(raw_w, raw_h, raw_r, $urandom_range(0, 5) % 4, $urandom_range(0, 3) == 0);
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    $display("Ran %0d frames with %0d transactions sent, %0d results compared.",
             frames_run, items_sent, checked);
    $display("Geometry ranged from clamped 3x3 up to 130-pixel rows, radius 1 to 3.");
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
